>>> rtl/lip_pkg.sv
package lip_pkg;

  localparam int QBITS = 32;
  localparam int DEN_W = 36;
  localparam int REM_W = 37;
  localparam int NUM_W = 53;

  typedef struct packed {
    logic               func;
    logic signed [15:0] ax;
    logic signed [15:0] xlo;
    logic signed [15:0] xhi;
    logic signed [15:0] ylo;
    logic signed [15:0] yhi;
  } side_t;

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [QBITS-1:0] shq;
    logic             neg;
    logic             ovf;
  } div_t;

  typedef struct packed {
    div_t             dx;
    div_t             dy;
    logic [DEN_W-1:0] den;
    logic             nz;
    side_t            side;
  } cell_t;

endpackage

>>> rtl/lip_div_cell.sv
module lip_div_cell
  import lip_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  cell_t in_data,
  output logic  out_valid,
  input  logic  out_ready,
  output cell_t out_data
);

  function automatic div_t step(div_t d, logic [DEN_W-1:0] den);
    logic [REM_W:0] t;
    logic           qb;
    div_t           r;
    t  = {d.rem, d.shq[QBITS-1]};
    qb = (t >= {2'b00, den});
    r  = d;
    r.rem = qb ? REM_W'(t - {2'b00, den}) : t[REM_W-1:0];
    r.shq = {d.shq[QBITS-2:0], qb};
    return r;
  endfunction

  cell_t data;
  cell_t data_next;
  logic  valid;

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_data  = data;

  always_comb begin
    data_next    = in_data;
    data_next.dx = step(in_data.dx, in_data.den);
    data_next.dy = step(in_data.dy, in_data.den);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      data <= data_next;
    end
  end

endmodule

>>> rtl/line_intersection_point.sv
// Intersection of two lines by Cramer's rule, Q16.16 result truncated toward zero
// and saturated. One word is accepted per cycle unless the pipeline stalls; six stages
// form coefficients, products, determinant and magnitudes, a row of 32 divider
// cells resolves one quotient bit of x and y each, and two stages saturate and
// compare. A stall on the result side backs up only through full stages.
module line_intersection_point
  import lip_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // first_ax, first_ay, first_bx, first_by, second_ax, second_ay, second_bx,
  // second_by, coef_a, coef_b, coef_c, zero pad
  input  logic [199:0] s_tdata,
  // func
  input  logic         s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // cross_x, cross_y, ahead_of_start, within_segment, zero pad
  output logic [71:0]  m_tdata,
  // valid_res
  output logic         m_tuser
);

  logic v1, v2, v3, v4, v5, v6, v7, v8;
  logic r1, r2, r3, r4, r5, r6, r7, r8;

  logic signed [15:0] i_ax, i_ay, i_bx, i_by, i_sax, i_say, i_sbx, i_sby;
  logic signed [17:0] i_ca, i_cb;
  logic signed [34:0] i_cc;

  assign i_ax  = s_tdata[15:0];
  assign i_ay  = s_tdata[31:16];
  assign i_bx  = s_tdata[47:32];
  assign i_by  = s_tdata[63:48];
  assign i_sax = s_tdata[79:64];
  assign i_say = s_tdata[95:80];
  assign i_sbx = s_tdata[111:96];
  assign i_sby = s_tdata[127:112];
  assign i_ca  = s_tdata[145:128];
  assign i_cb  = s_tdata[163:146];
  assign i_cc  = s_tdata[198:164];

  logic signed [17:0] s1_a1, s1_b1, s1_a2, s1_b2;
  logic signed [31:0] s1_p1, s1_p2, s1_q1, s1_q2;
  logic signed [34:0] s1_cc;
  side_t              s1_side;

  logic signed [17:0] s2_a1, s2_b1, s2_a2, s2_b2;
  logic signed [32:0] s2_c1;
  logic signed [34:0] s2_c2;
  side_t              s2_side;

  logic signed [50:0] s3_c1b2, s3_a2c1;
  logic signed [52:0] s3_c2b1, s3_a1c2;
  logic signed [35:0] s3_a1b2, s3_a2b1;
  side_t              s3_side;

  logic signed [36:0] s4_det;
  logic signed [53:0] s4_nx, s4_ny;
  side_t              s4_side;

  logic [NUM_W-1:0] s5_mx, s5_my;
  logic [DEN_W-1:0] s5_dm;
  logic             s5_negx, s5_negy, s5_nz;
  side_t            s5_side;

  cell_t s6;

  logic signed [31:0] s7_cx, s7_cy;
  logic               s7_nz;
  side_t              s7_side;

  logic signed [31:0] o_cx, o_cy;
  logic               o_val, o_ahead, o_within;

  logic  cv [0:QBITS];
  logic  cr [0:QBITS];
  cell_t cd [0:QBITS];

  assign r8 = !v8 || m_tready;
  assign r7 = !v7 || r8;
  assign r6 = !v6 || cr[0];
  assign r5 = !v5 || r6;
  assign r4 = !v4 || r5;
  assign r3 = !v3 || r4;
  assign r2 = !v2 || r3;
  assign r1 = !v1 || r2;
  assign s_tready = r1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0;
      v5 <= 1'b0; v6 <= 1'b0; v7 <= 1'b0; v8 <= 1'b0;
    end else begin
      if (r1) v1 <= s_tvalid;
      if (r2) v2 <= v1;
      if (r3) v3 <= v2;
      if (r4) v4 <= v3;
      if (r5) v5 <= v4;
      if (r6) v6 <= v5;
      if (r7) v7 <= cv[QBITS];
      if (r8) v8 <= v7;
    end
  end

  function automatic logic signed [31:0] sat(logic [QBITS-1:0] q, logic neg, logic ovf);
    logic signed [31:0] r;
    if (!neg) begin
      r = (ovf || q[31]) ? 32'sh7fffffff : signed'(q);
    end else begin
      r = (ovf || (q[31] && q[30:0] != '0)) ? 32'sh80000000 : signed'(-q);
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (r1) begin
      s1_a1 <= 18'(i_by) - 18'(i_ay);
      s1_b1 <= 18'(i_ax) - 18'(i_bx);
      s1_a2 <= s_tuser ? i_ca : 18'(i_sby) - 18'(i_say);
      s1_b2 <= s_tuser ? i_cb : 18'(i_sax) - 18'(i_sbx);
      s1_p1 <= i_ay * i_bx;
      s1_p2 <= i_ax * i_by;
      s1_q1 <= i_say * i_sbx;
      s1_q2 <= i_sax * i_sby;
      s1_cc <= i_cc;
      s1_side.func <= s_tuser;
      s1_side.ax   <= i_ax;
      s1_side.xlo  <= (i_sax < i_sbx) ? i_sax : i_sbx;
      s1_side.xhi  <= (i_sax < i_sbx) ? i_sbx : i_sax;
      s1_side.ylo  <= (i_say < i_sby) ? i_say : i_sby;
      s1_side.yhi  <= (i_say < i_sby) ? i_sby : i_say;
    end
    if (r2) begin
      s2_a1 <= s1_a1; s2_b1 <= s1_b1; s2_a2 <= s1_a2; s2_b2 <= s1_b2;
      s2_c1 <= 33'(s1_p1) - 33'(s1_p2);
      s2_c2 <= s1_side.func ? s1_cc : 35'(33'(s1_q1) - 33'(s1_q2));
      s2_side <= s1_side;
    end
    if (r3) begin
      s3_c1b2 <= s2_c1 * s2_b2;
      s3_a2c1 <= s2_a2 * s2_c1;
      s3_c2b1 <= s2_c2 * s2_b1;
      s3_a1c2 <= s2_a1 * s2_c2;
      s3_a1b2 <= s2_a1 * s2_b2;
      s3_a2b1 <= s2_a2 * s2_b1;
      s3_side <= s2_side;
    end
    if (r4) begin
      s4_det  <= 37'(s3_a1b2) - 37'(s3_a2b1);
      s4_nx   <= 54'(s3_c2b1) - 54'(s3_c1b2);
      s4_ny   <= 54'(s3_a2c1) - 54'(s3_a1c2);
      s4_side <= s3_side;
    end
    if (r5) begin
      s5_mx   <= s4_nx[53] ? NUM_W'(-s4_nx) : s4_nx[NUM_W-1:0];
      s5_my   <= s4_ny[53] ? NUM_W'(-s4_ny) : s4_ny[NUM_W-1:0];
      s5_dm   <= s4_det[36] ? DEN_W'(-s4_det) : s4_det[DEN_W-1:0];
      s5_negx <= s4_nx[53] ^ s4_det[36];
      s5_negy <= s4_ny[53] ^ s4_det[36];
      s5_nz   <= (s4_det != '0);
      s5_side <= s4_side;
    end
    if (r6) begin
      s6.dx.rem <= s5_mx[NUM_W-1:16];
      s6.dx.shq <= {s5_mx[15:0], 16'h0000};
      s6.dx.neg <= s5_negx;
      s6.dx.ovf <= (s5_mx[NUM_W-1:16] >= {1'b0, s5_dm});
      s6.dy.rem <= s5_my[NUM_W-1:16];
      s6.dy.shq <= {s5_my[15:0], 16'h0000};
      s6.dy.neg <= s5_negy;
      s6.dy.ovf <= (s5_my[NUM_W-1:16] >= {1'b0, s5_dm});
      s6.den    <= s5_dm;
      s6.nz     <= s5_nz;
      s6.side   <= s5_side;
    end
    if (r7) begin
      s7_cx   <= sat(cd[QBITS].dx.shq, cd[QBITS].dx.neg, cd[QBITS].dx.ovf);
      s7_cy   <= sat(cd[QBITS].dy.shq, cd[QBITS].dy.neg, cd[QBITS].dy.ovf);
      s7_nz   <= cd[QBITS].nz;
      s7_side <= cd[QBITS].side;
    end
    if (r8) begin
      o_val    <= s7_nz;
      o_cx     <= s7_nz ? s7_cx : 32'sd0;
      o_cy     <= s7_nz ? s7_cy : 32'sd0;
      o_ahead  <= s7_nz && (s7_cx > signed'({s7_side.ax, 16'h0000}));
      o_within <= s7_nz && !s7_side.func
                  && (s7_cx >= signed'({s7_side.xlo, 16'h0000}))
                  && (s7_cx <= signed'({s7_side.xhi, 16'h0000}))
                  && (s7_cy >= signed'({s7_side.ylo, 16'h0000}))
                  && (s7_cy <= signed'({s7_side.yhi, 16'h0000}));
    end
  end

  assign cv[0] = v6;
  assign cd[0] = s6;
  assign cr[QBITS] = r7;

  for (genvar i = 0; i < QBITS; i++) begin : g_cell
    lip_div_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .in_valid (cv[i]),
      .in_ready (cr[i]),
      .in_data  (cd[i]),
      .out_valid(cv[i+1]),
      .out_ready(cr[i+1]),
      .out_data (cd[i+1])
    );
  end

  assign m_tvalid = v8;
  assign m_tuser  = o_val;
  assign m_tdata  = {6'b000000, o_within, o_ahead, o_cy, o_cx};

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> (m_tdata == '0))
    else $error("parallel result not cleared");

  a_flags_need_valid: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tdata[64] || m_tdata[65])) |-> m_tuser)
    else $error("flag set without crossing");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (m_tvalid && !m_tready))
    else $error("input stalled while output free");

  a_hold_out: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("held word changed");

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps

module tb;
  import lip_pkg::*;

  typedef struct {
    bit              func;
    bit signed [15:0] ax, ay, bx, by;
    bit signed [15:0] sax, say, sbx, sby;
    bit signed [17:0] ca, cb;
    bit signed [34:0] cc;
  } query_t;

  typedef struct {
    bit              ok;
    bit signed [31:0] x, y;
    bit              ahead, in_box;
  } crossing_t;

  class crossing_board;
    crossing_t pending[$];
    int        errors;
    int        checked;

    function longint q16_quot(longint num, longint den);
      longint q, r, v;
      q = num / den;
      r = num % den;
      if (q > 40000) return 64'sd2147483647;
      if (q < -40000) return -64'sd2147483648;
      v = q * 65536 + (r * 65536) / den;
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function void note_query(query_t q);
      longint a1, b1, c1, a2, b2, c2, det, cx, cy, xlo, xhi, ylo, yhi;
      crossing_t e;
      a1 = longint'(q.by) - q.ay;
      b1 = longint'(q.ax) - q.bx;
      c1 = longint'(q.ay) * q.bx - longint'(q.ax) * q.by;
      if (!q.func) begin
        a2 = longint'(q.sby) - q.say;
        b2 = longint'(q.sax) - q.sbx;
        c2 = longint'(q.say) * q.sbx - longint'(q.sax) * q.sby;
      end else begin
        a2 = q.ca;
        b2 = q.cb;
        c2 = q.cc;
      end
      det = a1 * b2 - a2 * b1;
      e = '{default: 0};
      if (det != 0) begin
        cx = q16_quot(-(c1 * b2 - c2 * b1), det);
        cy = q16_quot(-(a1 * c2 - a2 * c1), det);
        e.ok = 1'b1;
        e.x = 32'(cx);
        e.y = 32'(cy);
        e.ahead = cx > longint'(q.ax) * 65536;
        if (!q.func) begin
          xlo = (q.sax < q.sbx ? q.sax : q.sbx) * 64'sd65536;
          xhi = (q.sax < q.sbx ? q.sbx : q.sax) * 64'sd65536;
          ylo = (q.say < q.sby ? q.say : q.sby) * 64'sd65536;
          yhi = (q.say < q.sby ? q.sby : q.say) * 64'sd65536;
          e.in_box = xlo <= cx && cx <= xhi && ylo <= cy && cy <= yhi;
        end
      end
      pending.push_back(e);
    endfunction

    function void check_word(bit ok, bit [71:0] d);
      crossing_t e;
      if (pending.size() == 0) begin
        $error("unexpected result word");
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      if (ok != e.ok) begin
        $error("valid_res exp %0d got %0d", e.ok, ok); errors++;
      end
      if ($signed(d[31:0]) != e.x) begin
        $error("cross_x exp %0d got %0d", e.x, $signed(d[31:0])); errors++;
      end
      if ($signed(d[63:32]) != e.y) begin
        $error("cross_y exp %0d got %0d", e.y, $signed(d[63:32])); errors++;
      end
      if (d[64] != e.ahead) begin
        $error("ahead_of_start exp %0d got %0d", e.ahead, d[64]); errors++;
      end
      if (d[65] != e.in_box) begin
        $error("within_segment exp %0d got %0d", e.in_box, d[65]); errors++;
      end
    endfunction
  endclass

  logic         clk = 0;
  logic         rst = 1;
  logic         s_tvalid = 0;
  logic         s_tready;
  logic [199:0] s_tdata = '0;
  logic         s_tuser = 0;
  logic         m_tvalid;
  logic         m_tready = 0;
  logic [71:0]  m_tdata;
  logic         m_tuser;

  crossing_board board = new();
  int send_idle = 0;
  int recv_stall = 0;
  bit done = 0;

  line_intersection_point dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) board.check_word(m_tuser, m_tdata);
      m_tready <= ($urandom_range(99) >= recv_stall);
    end
  end

  function bit [15:0] pick16();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($urandom_range(20)) - 16'd10;
      default: return 16'($urandom);
    endcase
  endfunction

  task send(query_t q);
    s_tvalid <= 1;
    s_tuser  <= q.func;
    s_tdata  <= {53'd0, q.cc, q.cb, q.ca, q.sby, q.sbx, q.say, q.sax,
                 q.by, q.bx, q.ay, q.ax};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    board.note_query(q);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 0;
      @(posedge clk);
    end
  endtask

  task send_points(int ax, int ay, int bx, int by, int sax, int say, int sbx, int sby);
    query_t q;
    q = '{default: 0};
    q.ax = 16'(ax); q.ay = 16'(ay); q.bx = 16'(bx); q.by = 16'(by);
    q.sax = 16'(sax); q.say = 16'(say); q.sbx = 16'(sbx); q.sby = 16'(sby);
    send(q);
  endtask

  task send_coef(int ax, int ay, int bx, int by, longint a, longint b, longint c);
    query_t q;
    q = '{default: 0};
    q.func = 1'b1;
    q.ax = 16'(ax); q.ay = 16'(ay); q.bx = 16'(bx); q.by = 16'(by);
    q.ca = 18'(a); q.cb = 18'(b); q.cc = 35'(c);
    q.sax = 16'h7fff; q.sby = 16'h8000;
    send(q);
  endtask

  task send_random();
    query_t q;
    q.func = 1'($urandom_range(1));
    q.ax = pick16(); q.ay = pick16(); q.bx = pick16(); q.by = pick16();
    q.sax = pick16(); q.say = pick16(); q.sbx = pick16(); q.sby = pick16();
    q.ca = 18'($urandom);
    q.cb = 18'($urandom);
    q.cc = {3'($urandom), 32'($urandom)};
    if ($urandom_range(3) == 0) begin
      q.ca = $urandom_range(1) ? 18'h20000 : 18'h1ffff;
      q.cc = $urandom_range(1) ? 35'h400000000 : 35'h3ffffffff;
    end
    if ($urandom_range(9) == 0) begin
      q.sax = q.ax; q.say = q.ay; q.sbx = q.bx; q.sby = q.by;
    end
    send(q);
  endtask

  initial begin
    int waited;
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    send_points(0, 0, 10, 10, 0, 10, 10, 0);
    send_points(-5, -5, 5, 5, -5, 5, 5, -5);
    send_points(0, 0, 1, 1, 0, 1, 1, 2);
    send_points(3, 3, 3, 3, 1, 2, 3, 4);
    send_points(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768);
    send_points(0, 0, 32767, 1, 0, 1, 32767, 1);
    send_points(-32768, 0, -32767, 1, 0, -32768, 1, -32768);
    send_points(0, 0, 1, 0, 5, 5, 5, 7);
    send_points(0, 0, 3, 1, 0, 1, 3, 0);
    send_coef(0, 0, 1, 1, 1, 1, 0);
    send_coef(0, 0, 1, 1, 1, -1, 0);
    send_coef(0, 0, 1, 0, 131071, -131072, 64'sd17179869183);
    send_coef(-32768, 32767, 32767, -32768, -131072, 1, -64'sd17179869184);
    send_coef(0, 0, 0, 1, 1, 0, -7);
    send_coef(1, 0, 0, 1, 3, 1, 64'sd17179869183);
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 55; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 55; end
        3: begin send_idle = 30; recv_stall = 30; end
        default: begin send_idle = 0; recv_stall = 0; end
      endcase
      repeat (200) send_random();
    end
    s_tvalid <= 0;
    recv_stall = 0;
    waited = 0;
    while (board.pending.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (60) @(posedge clk);
    $display("Checked %0d intersection results, point and coefficient forms,",
             board.checked);
    $display("with idle and stall phases on both stream sides.");
    if (board.errors == 0 && board.pending.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  initial begin
    #2ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule
